[rtl/pps_pkg.sv]
// Package: types, constants and helpers shared by the pressure projection solver.
`default_nettype none
package pps_pkg;

  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;
  localparam int VelW         = 32;
  localparam int SumW         = 38;
  localparam int CfgDataW     = 15;
  localparam int CfgIdxW      = 2;

  localparam logic [6:0]  GridWidthRst   = 7'd64;
  localparam logic [6:0]  GridHeightRst  = 7'd64;
  localparam logic [7:0]  SweepCountRst  = 8'd40;
  localparam logic [14:0] RelaxFactorRst = 15'd31130;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SOLVE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_SWEEP_COUNT  = 2'd2,
    REG_RELAX_FACTOR = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RDATA, S_RESP, S_CELL, S_RD_R, S_RD_T, S_RD_L, S_RD_B,
    S_CALC, S_MUL, S_PREP, S_DIV, S_WR_C, S_WR_R, S_WR_T, S_NEXT
  } state_e;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [5:0]             cell_x;
    logic [5:0]             cell_y;
    logic signed [VelW-1:0] u_in;
    logic signed [VelW-1:0] v_in;
    logic                   fluid_in;
  } in_word_t;

  typedef struct packed {
    logic signed [VelW-1:0] u_out;
    logic signed [VelW-1:0] v_out;
    logic                   fluid_out;
    logic                   saturated;
  } out_word_t;

  // One grid entry as it sits in the memory.
  typedef struct packed {
    logic                   fluid;
    logic signed [VelW-1:0] v;
    logic signed [VelW-1:0] u;
  } cell_t;

  localparam int CellW = $bits(cell_t);

  // Clips a wide sum to 32 bits; the top bit of the result flags a clip.
  function automatic logic [VelW:0] sat32(input logic signed [SumW-1:0] a);
    logic [VelW:0] r;
    if (a > SumW'(signed'({1'b0, {(VelW-1){1'b1}}}))) begin
      r = {1'b1, 1'b0, {(VelW-1){1'b1}}};
    end else if (a < -SumW'(signed'({1'b0, 1'b1, {(VelW-1){1'b0}}}))) begin
      r = {1'b1, 1'b1, {(VelW-1){1'b0}}};
    end else begin
      r = {1'b0, a[VelW-1:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/pps_stream_if.sv]
// Valid/ready channel carrying one word of a given type.
`default_nettype none
interface pps_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/pps_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none
module pps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

[rtl/pressure_projection_solver.sv]
// Pressure projection solver: the grid of u, v and fluid flags lives in one single-port RAM
// (MAX_WIDTH*MAX_HEIGHT words, one read or one write a cycle). A write passes through the
// response state to the output register, a read through the read-data and response states; a
// new command is taken only back in idle, and the response state waits while the output still
// holds a word not yet taken. A solve visits each interior cell of each sweep. A solid cell ends
// after the read of the cell; a fluid cell with no fluid neighbor ends after its neighbor reads.
// A fluid cell with fluid neighbors takes 5 reads, a multiply, a 36-step bit-serial division by
// the neighbor count and 3 write-backs. No clearing pass is needed; every cell must be written
// before it is read or solved over.
`default_nettype none
module pressure_projection_solver
  import pps_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  pps_stream_if.sink               cmd_i,
  pps_stream_if.source             res_o
);
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DimW  = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;
  localparam int DimH  = ($clog2(MAX_HEIGHT + 1) > 7) ? $clog2(MAX_HEIGHT + 1) : 7;
  localparam int MW    = 36;
  localparam int CW    = $clog2(MW);

  state_e state_q, state_d;

  logic [6:0]  grid_width_q, grid_height_q;
  logic [7:0]  sweep_count_q;
  logic [14:0] relax_q;

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [7:0]    sw_q, sw_d;
  logic          clip_q, clip_d;
  logic          rd_in_q, rd_in_d;

  cell_t cw_q, cw_d, rw_q, rw_d, tw_q, tw_d;
  logic  fl_q, fl_d, fb_q, fb_d;
  logic [2:0] k_q, k_d;
  logic signed [33:0] div_q, div_d;
  logic signed [49:0] prod_q, prod_d;
  logic [MW-1:0] num_q, num_d;
  logic [2:0]    rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pneg_q, pneg_d;

  out_word_t res_q, res_d, out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  cell_t         mem_wdata, mem_rdata;

  pps_ram #(.Width(CellW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Grid extent in use, clamped to 3..MAX.
  logic [DimW-1:0] w_use;
  logic [DimH-1:0] h_use;
  always_comb begin
    if (DimW'(grid_width_q) < DimW'(3)) w_use = DimW'(3);
    else if (DimW'(grid_width_q) > DimW'(MAX_WIDTH)) w_use = DimW'(MAX_WIDTH);
    else w_use = DimW'(grid_width_q);
    if (DimH'(grid_height_q) < DimH'(3)) h_use = DimH'(3);
    else if (DimH'(grid_height_q) > DimH'(MAX_HEIGHT)) h_use = DimH'(MAX_HEIGHT);
    else h_use = DimH'(grid_height_q);
  end

  logic x_last, y_last, sw_last;
  assign x_last  = (DimW'(x_q) == DimW'(w_use - DimW'(2)));
  assign y_last  = (DimH'(y_q) == DimH'(h_use - DimH'(2)));
  assign sw_last = ({1'b0, sw_q} + 9'd1) == {1'b0, sweep_count_q};

  logic [AW-1:0] a_c, a_l, a_r, a_b, a_t, a_in;
  logic          in_inside;
  assign a_c = AW'(AW'(x_q) * AW'(MAX_HEIGHT)) + AW'(y_q);
  assign a_l = a_c - AW'(MAX_HEIGHT);
  assign a_r = a_c + AW'(MAX_HEIGHT);
  assign a_b = a_c - AW'(1);
  assign a_t = a_c + AW'(1);
  assign a_in = AW'(32'(cmd_i.data.cell_x) * 32'(MAX_HEIGHT) + 32'(cmd_i.data.cell_y));
  assign in_inside = (32'(cmd_i.data.cell_x) < 32'(MAX_WIDTH)) &&
                     (32'(cmd_i.data.cell_y) < 32'(MAX_HEIGHT));

  // Divider step and velocity updates.
  logic [3:0]  rem_sh;
  logic signed [36:0] p_val;
  logic [VelW:0] s_uc, s_vc, s_ur, s_vt;
  logic signed [35:0] q_val;
  logic [MW-1:0] q_mag;
  always_comb begin
    rem_sh = {rem_q, num_q[MW-1]};
    q_val  = prod_q[49:14];
    q_mag  = q_val[35] ? MW'(-q_val) : MW'(q_val);
    p_val  = pneg_q ? -signed'({1'b0, num_q}) : signed'({1'b0, num_q});
    s_uc = sat32(SumW'(cw_q.u) - (fl_q ? SumW'(p_val) : SumW'(0)));
    s_vc = sat32(SumW'(cw_q.v) - (fb_q ? SumW'(p_val) : SumW'(0)));
    s_ur = sat32(SumW'(rw_q.u) + (rw_q.fluid ? SumW'(p_val) : SumW'(0)));
    s_vt = sat32(SumW'(tw_q.v) + (tw_q.fluid ? SumW'(p_val) : SumW'(0)));
  end

  assign cmd_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_comb begin
    state_d = state_q;
    x_d = x_q; y_d = y_q; sw_d = sw_q; clip_d = clip_q; rd_in_d = rd_in_q;
    cw_d = cw_q; rw_d = rw_q; tw_d = tw_q; fl_d = fl_q; fb_d = fb_q; k_d = k_q;
    div_d = div_q; prod_d = prod_q; num_d = num_q; rem_d = rem_q; cnt_d = cnt_q;
    pneg_d = pneg_q; res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    mem_we = 1'b0; mem_addr = a_c; mem_wdata = cw_q;
    case (state_q)
      S_IDLE: begin
        mem_addr  = a_in;
        mem_wdata = '{fluid: cmd_i.data.fluid_in, v: cmd_i.data.v_in, u: cmd_i.data.u_in};
        if (cmd_i.valid) begin
          res_d = '0;
          state_d = S_RESP;
          case (cmd_e'(cmd_i.data.cmd))
            CMD_WRITE: mem_we = in_inside;
            CMD_READ: begin
              rd_in_d = in_inside;
              state_d = S_RDATA;
            end
            CMD_SOLVE: begin
              clip_d = 1'b0;
              x_d = XW'(1); y_d = YW'(1); sw_d = '0;
              if (sweep_count_q != '0) state_d = S_CELL;
            end
            default: ;
          endcase
        end
      end
      S_RDATA: begin
        if (rd_in_q) begin
          res_d.u_out = mem_rdata.u;
          res_d.v_out = mem_rdata.v;
          res_d.fluid_out = mem_rdata.fluid;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || res_o.ready) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CELL: begin
        mem_addr = a_c;
        state_d = S_RD_R;
      end
      S_RD_R: begin
        cw_d = mem_rdata;
        mem_addr = a_r;
        state_d = mem_rdata.fluid ? S_RD_T : S_NEXT;
      end
      S_RD_T: begin
        rw_d = mem_rdata;
        mem_addr = a_t;
        state_d = S_RD_L;
      end
      S_RD_L: begin
        tw_d = mem_rdata;
        mem_addr = a_l;
        state_d = S_RD_B;
      end
      S_RD_B: begin
        fl_d = mem_rdata.fluid;
        mem_addr = a_b;
        state_d = S_CALC;
      end
      S_CALC: begin
        fb_d = mem_rdata.fluid;
        k_d = 3'(fl_q) + 3'(mem_rdata.fluid) + 3'(rw_q.fluid) + 3'(tw_q.fluid);
        div_d = 34'(rw_q.u) - 34'(cw_q.u) + 34'(tw_q.v) - 34'(cw_q.v);
        state_d = (k_d == '0) ? S_NEXT : S_MUL;
      end
      S_MUL: begin
        prod_d = 50'(div_q) * 50'(signed'({1'b0, relax_q}));
        state_d = S_PREP;
      end
      S_PREP: begin
        // The pressure takes the opposite sign of the scaled divergence.
        pneg_d = !q_val[35];
        num_d = q_mag;
        rem_d = '0;
        cnt_d = CW'(MW - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, k_q}) begin
          rem_d = 3'(rem_sh - {1'b0, k_q});
          num_d = {num_q[MW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[2:0];
          num_d = {num_q[MW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) state_d = S_WR_C;
      end
      S_WR_C: begin
        mem_we = 1'b1;
        mem_addr = a_c;
        mem_wdata = '{fluid: cw_q.fluid, v: s_vc[VelW-1:0], u: s_uc[VelW-1:0]};
        clip_d = clip_q | s_uc[VelW] | s_vc[VelW];
        state_d = S_WR_R;
      end
      S_WR_R: begin
        mem_we = 1'b1;
        mem_addr = a_r;
        mem_wdata = '{fluid: rw_q.fluid, v: rw_q.v, u: s_ur[VelW-1:0]};
        clip_d = clip_q | s_ur[VelW];
        state_d = S_WR_T;
      end
      S_WR_T: begin
        mem_we = 1'b1;
        mem_addr = a_t;
        mem_wdata = '{fluid: tw_q.fluid, v: s_vt[VelW-1:0], u: tw_q.u};
        clip_d = clip_q | s_vt[VelW];
        state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = S_CELL;
        if (!y_last) begin
          y_d = y_q + YW'(1);
        end else begin
          y_d = YW'(1);
          if (!x_last) begin
            x_d = x_q + XW'(1);
          end else begin
            x_d = XW'(1);
            sw_d = sw_q + 8'd1;
            if (sw_last) begin
              res_d = '0;
              res_d.saturated = clip_q;
              state_d = S_RESP;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      grid_width_q  <= GridWidthRst;
      grid_height_q <= GridHeightRst;
      sweep_count_q <= SweepCountRst;
      relax_q       <= RelaxFactorRst;
      x_q <= XW'(1); y_q <= YW'(1); sw_q <= '0; cnt_q <= '0;
      clip_q <= 1'b0; rd_in_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      x_q <= x_d; y_q <= y_d; sw_q <= sw_d; cnt_q <= cnt_d;
      clip_q <= clip_d; rd_in_q <= rd_in_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_GRID_WIDTH:   grid_width_q  <= cfg_data_i[6:0];
          REG_GRID_HEIGHT:  grid_height_q <= cfg_data_i[6:0];
          REG_SWEEP_COUNT:  sweep_count_q <= cfg_data_i[7:0];
          REG_RELAX_FACTOR: relax_q       <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q <= cw_d; rw_q <= rw_d; tw_q <= tw_d; fl_q <= fl_d; fb_q <= fb_d; k_q <= k_d;
    div_q <= div_d; prod_q <= prod_d; num_q <= num_d; rem_q <= rem_d;
    pneg_q <= pneg_d; res_q <= res_d; out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE || state_q == S_WR_C || state_q == S_WR_R ||
                state_q == S_WR_T))
    else $error("RAM written outside a write step");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> state_q == S_WR_C)
    else $error("divider did not hand over to write-back");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result word appeared outside the response step");
  a_k_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> k_q != '0)
    else $error("division by a zero neighbor count");
`endif
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the pressure projection solver: grid load, read-back and solves.
`timescale 1ns / 100ps
module tb_top;
  import pps_pkg::*;

  localparam int GridCells  = DefMaxWidth * DefMaxHeight;
  localparam int IdleLimit  = 1000000;
  localparam int DrainDelay = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pps_stream_if #(.T(in_word_t))  cmd_if ();
  pps_stream_if #(.T(out_word_t)) res_if ();

  pressure_projection_solver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the grid and the registers.
  logic signed [VelW-1:0] u_shadow [GridCells];
  logic signed [VelW-1:0] v_shadow [GridCells];
  bit                     fluid_shadow [GridCells];
  bit                     written [GridCells];
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  logic [7:0]  sweeps_reg;
  logic [14:0] relax_reg;
  bit          clipped;

  out_word_t readback_q [$];
  int  mismatches;
  int  words_out;
  int  idle_cycles;
  bit  tx_burst;
  bit  rx_burst;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_row_t;
  stim_row_t stim_rows [$];

  function automatic int clamp_dim(int d);
    if (d < 3) return 3;
    if (d > 64) return 64;
    return d;
  endfunction

  function automatic logic signed [VelW-1:0] clip32(longint a);
    if (a > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7fffffff;
    end
    if (a < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return a[VelW-1:0];
  endfunction

  function automatic void relax_one(int x, int y);
    int c, l, r, b, t;
    longint k, dv, q, p;
    c = x * DefMaxHeight + y;
    l = c - DefMaxHeight;
    r = c + DefMaxHeight;
    b = c - 1;
    t = c + 1;
    if (!fluid_shadow[c]) return;
    k = fluid_shadow[l] + fluid_shadow[r] + fluid_shadow[b] + fluid_shadow[t];
    if (k == 0) return;
    dv = longint'(u_shadow[r]) - longint'(u_shadow[c])
       + longint'(v_shadow[t]) - longint'(v_shadow[c]);
    q = (dv * longint'(relax_reg)) >>> 14;
    p = (-q) / k;
    u_shadow[c] = clip32(longint'(u_shadow[c]) - (fluid_shadow[l] ? p : 0));
    u_shadow[r] = clip32(longint'(u_shadow[r]) + (fluid_shadow[r] ? p : 0));
    v_shadow[c] = clip32(longint'(v_shadow[c]) - (fluid_shadow[b] ? p : 0));
    v_shadow[t] = clip32(longint'(v_shadow[t]) + (fluid_shadow[t] ? p : 0));
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t o;
    int c, gw, gh;
    o = '0;
    c = int'(w.cell_x) * DefMaxHeight + int'(w.cell_y);
    case (cmd_e'(w.cmd))
      CMD_WRITE: begin
        u_shadow[c] = w.u_in;
        v_shadow[c] = w.v_in;
        fluid_shadow[c] = w.fluid_in;
        written[c] = 1'b1;
      end
      CMD_READ: begin
        o.u_out = u_shadow[c];
        o.v_out = v_shadow[c];
        o.fluid_out = fluid_shadow[c];
      end
      CMD_SOLVE: begin
        clipped = 1'b0;
        gw = clamp_dim(width_reg);
        gh = clamp_dim(height_reg);
        for (int s = 0; s < sweeps_reg; s++)
          for (int x = 1; x + 1 < gw; x++)
            for (int y = 1; y + 1 < gh; y++)
              relax_one(x, y);
        o.saturated = clipped;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic in_word_t make_word(cmd_e cmd, int x, int y,
                                         logic [31:0] u, logic [31:0] v, bit f);
    in_word_t w;
    w.cmd = cmd;
    w.cell_x = 6'(x);
    w.cell_y = 6'(y);
    w.u_in = u;
    w.v_in = v;
    w.fluid_in = f;
    return w;
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, int value);
    // Stop offering words, then let a finished solve settle before touching the registers.
    cmd_if.valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk_i);
    repeat (DrainDelay) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:   width_reg = value[6:0];
      REG_GRID_HEIGHT:  height_reg = value[6:0];
      REG_SWEEP_COUNT:  sweeps_reg = value[7:0];
      REG_RELAX_FACTOR: relax_reg = value[14:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(int gw, int gh, int sw, int rf);
    write_reg(REG_GRID_WIDTH, gw);
    write_reg(REG_GRID_HEIGHT, gh);
    write_reg(REG_SWEEP_COUNT, sw);
    write_reg(REG_RELAX_FACTOR, rf);
  endtask

  // The expected word is taken at the acceptance edge, in command order.
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    int gap;
    out_word_t predicted;
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= w;
    do @(posedge clk_i); while (!cmd_if.ready);
    predicted = apply_command(w);
    readback_q.push_back(typed ? want : predicted);
  endtask

  task automatic send(in_word_t w);
    send_word(w, 1'b0, '0);
  endtask

  task automatic fill_grid(int gw, int gh);
    for (int x = 0; x < clamp_dim(gw); x++)
      for (int y = 0; y < clamp_dim(gh); y++)
        send(make_word(CMD_WRITE, x, y, rand_vel(), rand_vel(), $urandom_range(0, 3) != 0));
  endtask

  task automatic random_ops(int count);
    int gw, gh, x, y;
    gw = clamp_dim(width_reg);
    gh = clamp_dim(height_reg);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          x = $urandom_range(0, gw - 1);
          y = $urandom_range(0, gh - 1);
          send(make_word(CMD_WRITE, x, y, rand_vel(), rand_vel(), $urandom_range(0, 3) != 0));
        end
        7: send(make_word(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom, $urandom, 1'($urandom_range(0, 1))));
        8, 9, 10, 11, 12, 13, 14: begin
          do begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
            if ($urandom_range(0, 3) != 0) begin
              x = $urandom_range(0, gw - 1);
              y = $urandom_range(0, gh - 1);
            end
          end while (!written[x * DefMaxHeight + y]);
          send(make_word(CMD_READ, x, y, $urandom, $urandom, 1'($urandom_range(0, 1))));
        end
        15, 16, 17: send(make_word(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom, $urandom, 1'($urandom_range(0, 1))));
        default: send(make_word(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom, $urandom, 1'($urandom_range(0, 1))));
      endcase
    end
  endtask

  function automatic void add_row(in_word_t w, bit typed, out_word_t want);
    stim_row_t r;
    r.word = w;
    r.typed = typed;
    r.want = want;
    stim_rows.push_back(r);
  endfunction

  function automatic out_word_t readback(logic [31:0] u, logic [31:0] v, bit f);
    out_word_t o;
    o.u_out = u;
    o.v_out = v;
    o.fluid_out = f;
    o.saturated = 1'b0;
    return o;
  endfunction

  // Result side: random stalls, one long hold-off, and the comparison.
  initial begin
    out_word_t got, want;
    int gap;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (words_out == 60) gap = 600;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got = res_if.data;
      words_out++;
      if (readback_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", got);
      end else begin
        want = readback_q.pop_front();
        if (got.u_out !== want.u_out || got.v_out !== want.v_out ||
            got.fluid_out !== want.fluid_out || got.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected u=%h v=%h f=%b s=%b, got u=%h v=%h f=%b s=%b",
                     want.u_out, want.v_out, want.fluid_out, want.saturated,
                     got.u_out, got.v_out, got.fluid_out, got.saturated);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    mismatches = 0;
    words_out = 0;
    idle_cycles = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    width_reg = GridWidthRst;
    height_reg = GridHeightRst;
    sweeps_reg = SweepCountRst;
    relax_reg = RelaxFactorRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on a 3x3 grid; width and height below the minimum clamp to 3.
    set_grid(2, 1, 3, 31130);
    for (int x = 0; x < 3; x++)
      for (int y = 0; y < 3; y++)
        add_row(make_word(CMD_WRITE, x, y, 32'(x * 65536 - y * 4096),
                          32'(y * 32768 + x), (x + y) % 3 != 2), 1'b1, '0);
    add_row(make_word(CMD_WRITE, 63, 63, 32'h7fffffff, 32'h80000000, 1'b1), 1'b1, '0);
    add_row(make_word(CMD_READ, 63, 63, 32'h0, 32'h0, 1'b0), 1'b1,
            readback(32'h7fffffff, 32'h80000000, 1'b1));
    add_row(make_word(CMD_WRITE, 0, 63, 32'h80000000, 32'h7fffffff, 1'b0), 1'b1, '0);
    add_row(make_word(CMD_READ, 0, 63, 32'hffffffff, 32'hffffffff, 1'b1), 1'b1,
            readback(32'h80000000, 32'h7fffffff, 1'b0));
    add_row(make_word(CMD_NONE, 63, 63, 32'hffffffff, 32'hffffffff, 1'b1), 1'b1, '0);
    add_row(make_word(CMD_READ, 1, 1, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(make_word(CMD_SOLVE, 0, 0, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(make_word(CMD_READ, 1, 1, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(make_word(CMD_READ, 2, 1, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(make_word(CMD_WRITE, 2, 1, 32'h7fffffff, 32'h7fffffff, 1'b1), 1'b0, '0);
    add_row(make_word(CMD_WRITE, 1, 2, 32'h80000000, 32'h80000000, 1'b1), 1'b0, '0);
    add_row(make_word(CMD_SOLVE, 0, 0, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    add_row(make_word(CMD_READ, 1, 1, 32'h0, 32'h0, 1'b0), 1'b0, '0);
    foreach (stim_rows[i]) send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);

    // Longest sweep count with the largest factor, then zero sweeps with zero relaxation.
    set_grid(3, 3, 255, 32767);
    random_ops(40);
    set_grid(3, 3, 0, 0);
    random_ops(30);

    // Full-width strip, with an oversized width clamped to the maximum and a single sweep.
    set_grid(127, 3, 1, 16384);
    fill_grid(127, 3);
    send(make_word(CMD_SOLVE, 0, 0, 32'h0, 32'h0, 1'b0));
    random_ops(40);

    for (int ph = 0; ph < 8; ph++) begin
      set_grid($urandom_range(3, 9), $urandom_range(3, 9), $urandom_range(0, 6),
               $urandom_range(0, 32767));
      fill_grid(width_reg, height_reg);
      random_ops(40);
    end
    cmd_if.valid <= 1'b0;

    while (readback_q.size() != 0) @(posedge clk_i);
    repeat (DrainDelay) @(posedge clk_i);
    if (mismatches == 0 && readback_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
